FILE: src/arpc_pkg.sv
// Shared types and constants for the ARP cache responder.
// No dependencies; used by every module in src.
package arpc_pkg;

    localparam logic [15:0] ETH_ARP = 16'h0806;
    localparam logic [15:0] OP_REQ  = 16'd1;
    localparam logic [15:0] OP_REP  = 16'd2;

    localparam logic [1:0] REQ_FRAME  = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_RM_MISS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam int          CFG_IDX_W     = 2;
    localparam logic [1:0]  CFG_LOCAL_IP  = 2'd0;
    localparam logic [1:0]  CFG_LOCAL_MAC = 2'd1;

    localparam logic [7:0]  BCAST_BYTE = 8'hFF;
    localparam logic [47:0] BCAST_MAC  = {6{BCAST_BYTE}};

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] frame_type;
        logic [15:0] arp_oper;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [31:0] query_ip;
    } cmd_t;

    typedef struct packed {
        logic        reply_valid;
        logic [47:0] reply_dst_mac;
        logic [47:0] reply_src_mac;
        logic [15:0] reply_op;
        logic [31:0] reply_sender_ip;
        logic [31:0] reply_target_ip;
        logic        lookup_hit;
        logic [47:0] lookup_mac;
        logic [1:0]  status;
    } result_t;

    typedef enum logic [2:0] {
        K_IGNORE = 3'd0,
        K_ARP_REQ = 3'd1,
        K_ARP_REP = 3'd2,
        K_LOOKUP = 3'd3,
        K_REMOVE = 3'd4
    } kind_t;

    // classified item handed from front to back
    typedef struct packed {
        kind_t       kind;
        logic [31:0] key_ip;   // cache key: sender IP or query IP
        logic [31:0] aux_ip;   // request target IP, for replies
        logic [47:0] mac;
    } task_t;

endpackage

FILE: src/arpc_front.sv
// Front end: classifies an accepted item into a cache task.
// Depends on arpc_pkg.
module arpc_front (
    input  arpc_pkg::cmd_t  cmd,
    input  logic [31:0]     local_ip,
    output arpc_pkg::task_t tsk
);

    logic for_us;

    assign for_us = (cmd.frame_type == arpc_pkg::ETH_ARP) && (cmd.target_ip == local_ip);

    always_comb
    begin
        tsk.kind   = arpc_pkg::K_IGNORE;
        tsk.key_ip = cmd.query_ip;
        tsk.aux_ip = cmd.target_ip;
        tsk.mac    = cmd.sender_mac;
        unique case (cmd.req_type)
            arpc_pkg::REQ_FRAME:
            begin
                tsk.key_ip = cmd.sender_ip;
                if (for_us && cmd.arp_oper == arpc_pkg::OP_REQ)
                    tsk.kind = arpc_pkg::K_ARP_REQ;
                else if (for_us && cmd.arp_oper == arpc_pkg::OP_REP)
                    tsk.kind = arpc_pkg::K_ARP_REP;
            end
            arpc_pkg::REQ_LOOKUP: tsk.kind = arpc_pkg::K_LOOKUP;
            arpc_pkg::REQ_REMOVE: tsk.kind = arpc_pkg::K_REMOVE;
            default:              tsk.kind = arpc_pkg::K_IGNORE;
        endcase
    end

endmodule

FILE: src/arpc_fifo.sv
// Two-entry queue between front and back.
// Depends on arpc_pkg.
module arpc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  arpc_pkg::task_t wdata,
    input  logic            pop,
    output arpc_pkg::task_t rdata,
    output logic            not_empty,
    output logic            full
);

    arpc_pkg::task_t mem_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg, count_next;

    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign rdata     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

FILE: src/arpc_back.sv
// Back end: register CAM holding the IP-to-MAC cache; executes one task
// a cycle and registers the result. Depends on arpc_pkg.
module arpc_back #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  arpc_pkg::task_t   tsk,
    input  logic [47:0]       local_mac,
    output logic              done,
    output arpc_pkg::result_t result
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]              ip_reg  [TABLE_ENTRIES];
    logic [47:0]              mac_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] match;
    logic [IDX_W-1:0]         hit_idx, free_idx;
    logic                     hit, tbl_full, do_insert;
    arpc_pkg::result_t        res_next;
    logic                     done_reg;
    arpc_pkg::result_t        result_reg;

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (ip_reg[i] == tsk.key_ip);
            if (match[i])
                hit_idx = IDX_W'(i);
            if (!valid_reg[i])
                free_idx = IDX_W'(i);
        end
    end

    assign hit      = |match;
    assign tbl_full = &valid_reg;

    always_comb
    begin
        res_next        = '0;
        res_next.status = arpc_pkg::ST_IGNORED;
        valid_next      = valid_reg;
        do_insert       = 1'b0;
        case (tsk.kind)
            arpc_pkg::K_ARP_REQ:
            begin
                res_next.reply_valid     = 1'b1;
                res_next.reply_dst_mac   = tsk.mac;
                res_next.reply_src_mac   = local_mac;
                res_next.reply_op        = arpc_pkg::OP_REP;
                res_next.reply_sender_ip = tsk.aux_ip;
                res_next.reply_target_ip = tsk.key_ip;
                res_next.status          = arpc_pkg::ST_DONE;
            end
            arpc_pkg::K_ARP_REP:
            begin
                // already cached: entry left as is
                res_next.status = arpc_pkg::ST_DONE;
                if (!hit && tbl_full)
                    res_next.status = arpc_pkg::ST_FULL;
                else if (!hit)
                begin
                    do_insert            = 1'b1;
                    valid_next[free_idx] = 1'b1;
                end
            end
            arpc_pkg::K_LOOKUP:
            begin
                res_next.lookup_hit = hit;
                res_next.lookup_mac = hit ? mac_reg[hit_idx] : arpc_pkg::BCAST_MAC;
                res_next.status     = arpc_pkg::ST_DONE;
            end
            arpc_pkg::K_REMOVE:
            begin
                if (hit)
                begin
                    valid_next[hit_idx] = 1'b0;
                    res_next.status     = arpc_pkg::ST_DONE;
                end
                else
                    res_next.status = arpc_pkg::ST_RM_MISS;
            end
            default: res_next.status = arpc_pkg::ST_IGNORED;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= go;
            if (go)
                valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
            result_reg <= res_next;
        if (go && do_insert)
        begin
            ip_reg[free_idx]  <= tsk.key_ip;
            mac_reg[free_idx] <= tsk.mac;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: src/arp_cache_responder.sv
// Top level of the ARP cache responder: config registers, front, queue, back.
// Depends on arpc_pkg, arpc_front, arpc_fifo, arpc_back.
//
// Usage:
//   Command channel: drive cmd and raise start; the item is taken at a clock
//   edge where start is high and busy is low. busy is high while the two-entry
//   queue is full.
//   Result channel: every item yields exactly one result, shown on result for
//   one cycle with done high. Results come out in item order.
//   Each item passes through the queue and then the back end's result register.
//   Throughput: one item per cycle, set by the parallel compare over all cache
//   entries in the back end.
//   Config: cfg_valid/cfg_ready write local_ip (index 0) or local_mac
//   (index 1); cfg_ready is always high. Write only while no item is in flight.
//   Reset: clears the config registers, the queue and all cache valid bits,
//   so the table is empty at once. The receiver cannot stall: done is a
//   strobe and results are never held.
module arp_cache_responder #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  arpc_pkg::cmd_t                  cmd,
    output logic                            done,
    output arpc_pkg::result_t               result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [47:0]                     cfg_data
);

    logic [31:0]     local_ip_reg;
    logic [47:0]     local_mac_reg;
    arpc_pkg::task_t f_task, q_task;
    logic            q_valid, q_full, accept;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg  <= '0;
            local_mac_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                arpc_pkg::CFG_LOCAL_IP:  local_ip_reg  <= cfg_data[31:0];
                arpc_pkg::CFG_LOCAL_MAC: local_mac_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    arpc_front u_front (
        .cmd      (cmd),
        .local_ip (local_ip_reg),
        .tsk      (f_task)
    );

    arpc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .wdata     (f_task),
        .pop       (q_valid),
        .rdata     (q_task),
        .not_empty (q_valid),
        .full      (q_full)
    );

    arpc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (q_valid),
        .tsk       (q_task),
        .local_mac (local_mac_reg),
        .done      (done),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> q_valid)
        else $error("accepted item missing from queue");

    a_reply_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.reply_valid |-> result.status == arpc_pkg::ST_DONE)
        else $error("reply with non-done status");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.lookup_hit |-> result.status == arpc_pkg::ST_DONE && !result.reply_valid)
        else $error("lookup hit with bad status");
`endif

endmodule
